[src/icmp_echo_responder_assert.svh]
// Assertion macros shared by the checker.
`ifndef ICMP_ECHO_RESPONDER_ASSERT_SVH
`define ICMP_ECHO_RESPONDER_ASSERT_SVH

// Same-cycle implication.
`define IER_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IER_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ier_pkg.sv]
package ier_pkg;

  localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
  localparam logic [7:0] TYPE_ECHO_REPLY   = 8'd0;
  localparam logic [7:0] CODE_ECHO_REPLY   = 8'd0;
  localparam int         HEADER_BYTES      = 8;
  localparam int         SUM_START         = 4;
  localparam int         SUM_W             = 22;

  // reply byte positions in the header
  localparam int IDX_TYPE  = 0;
  localparam int IDX_CODE  = 1;
  localparam int IDX_CK_HI = 2;
  localparam int IDX_CK_LO = 3;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
  } ier_req_t;

  typedef struct packed {
    logic [7:0]  reply_byte;
    logic        reply_last;
    logic [31:0] reply_addr;
  } ier_reply_t;

  typedef struct packed {
    logic ingest;
    logic clear;
    logic fold;
    logic step;
  } ier_cmd_t;

  typedef struct packed {
    logic drop;
    logic emit_last;
  } ier_status_t;

  function automatic logic [15:0] fold_checksum(input logic [SUM_W-1:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, s[15:0]} + {11'd0, s[SUM_W-1:16]};
    s2 = {1'b0, s1[15:0]} + {16'd0, s1[16]};
    return ~s2[15:0];
  endfunction

endpackage

[src/ier_ctrl.sv]
module ier_ctrl import ier_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        last_byte,
  input  ier_status_t status,
  output ier_cmd_t    cmd,
  output logic        busy,
  output logic        reply_valid
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FOLD = 3'b010,
    ST_EMIT = 3'b100
  } ier_state_t;

  ier_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.ingest = 1'b1;
          if (last_byte) begin
            if (status.drop) begin
              cmd.clear = 1'b1;
            end else begin
              state_next = ST_FOLD;
            end
          end
        end
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.step = 1'b1;
        if (status.emit_last) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state != ST_IDLE);
  assign reply_valid = (state == ST_EMIT);

endmodule

[src/ier_datapath.sv]
module ier_datapath import ier_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  ier_req_t    request,
  input  ier_cmd_t    cmd,
  input  logic        cfg_wr,
  input  logic [31:0] cfg_data,
  output ier_status_t status,
  output ier_reply_t  reply
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int AW = $clog2(BUFFER_BYTES);

  logic [7:0]       mem [BUFFER_BYTES];
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic             overflow;
  logic             type_ok;
  logic [SUM_W-1:0] word_sum;
  logic [15:0]      checksum;
  logic [31:0]      local_addr;
  logic [31:0]      reply_addr;
  logic [7:0]       rd_data;

  logic             full;
  logic [CW-1:0]    count_next;
  logic             type_ok_next;
  logic [SUM_W-1:0] word_add;
  logic [CW-1:0]    idx_inc;

  assign full         = (count == CW'(BUFFER_BYTES));
  assign count_next   = full ? count : count + CW'(1);
  assign type_ok_next = (count == '0) ? (request.data_byte == TYPE_ECHO_REQUEST) : type_ok;
  assign word_add     = count[0] ? {{(SUM_W-8){1'b0}}, request.data_byte}
                                 : {{(SUM_W-16){1'b0}}, request.data_byte, 8'd0};
  assign idx_inc      = idx + CW'(1);

  assign status.drop = overflow || full || (count_next < CW'(HEADER_BYTES)) ||
                       !type_ok_next || (request.dest_addr != local_addr);
  assign status.emit_last = (idx_inc == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= '0;
    end else if (cfg_wr) begin
      local_addr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count    <= '0;
      overflow <= 1'b0;
      type_ok  <= 1'b0;
      word_sum <= '0;
      idx      <= '0;
    end else if (cmd.ingest) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        count   <= count_next;
        type_ok <= type_ok_next;
        if (count >= CW'(SUM_START)) begin
          word_sum <= word_sum + word_add;
        end
      end
    end else if (cmd.step) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ingest && !full) begin
      mem[count[AW-1:0]] <= request.data_byte;
    end
    if (cmd.ingest && request.last_byte) begin
      reply_addr <= request.source_addr;
    end
    if (cmd.fold) begin
      checksum <= fold_checksum(word_sum);
    end
    rd_data <= mem[idx_inc[AW-1:0]];
  end

  always_comb begin
    reply.reply_addr = reply_addr;
    reply.reply_last = status.emit_last;
    if (idx == CW'(IDX_TYPE)) begin
      reply.reply_byte = TYPE_ECHO_REPLY;
    end else if (idx == CW'(IDX_CODE)) begin
      reply.reply_byte = CODE_ECHO_REPLY;
    end else if (idx == CW'(IDX_CK_HI)) begin
      reply.reply_byte = checksum[15:8];
    end else if (idx == CW'(IDX_CK_LO)) begin
      reply.reply_byte = checksum[7:0];
    end else begin
      reply.reply_byte = rd_data;
    end
  end

endmodule

[src/icmp_echo_responder.sv]
// The first reply byte is shown in ST_EMIT, entered via ST_FOLD after the last byte.
// Throughput: one request byte per cycle while idle; an answered n-byte message then
// holds busy for one checksum fold and then the emission of its n reply bytes.
// Dropped messages never raise busy. The receiver cannot stall the reply.
// Reset (rst, synchronous): controller idle, message state and local_addr cleared.
module icmp_echo_responder import ier_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  ier_req_t    request,
  output logic        reply_valid,
  output ier_reply_t  reply,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  ier_cmd_t    cmd;
  ier_status_t status;

  assign cfg_ready = 1'b1;

  ier_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .last_byte   (request.last_byte),
    .status      (status),
    .cmd         (cmd),
    .busy        (busy),
    .reply_valid (reply_valid)
  );

  ier_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .request  (request),
    .cmd      (cmd),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .status   (status),
    .reply    (reply)
  );

endmodule

[src/ier_checker.sv]
`include "icmp_echo_responder_assert.svh"

module ier_checker import ier_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        reply_valid,
  input ier_reply_t  reply
);

  `IER_ASSERT_NOW(a_reply_while_busy, clk, rst, reply_valid, busy, "reply outside busy")
  `IER_ASSERT_NEXT(a_reply_contiguous, clk, rst, reply_valid && !reply.reply_last, reply_valid, "gap in reply")
  `IER_ASSERT_NEXT(a_reply_ends, clk, rst, reply_valid && reply.reply_last, !reply_valid, "reply after last")
  `IER_ASSERT_NEXT(a_addr_stable, clk, rst, reply_valid && !reply.reply_last, $stable(reply.reply_addr), "reply addr moved")
  `IER_ASSERT_NOW(a_type_first, clk, rst, $rose(reply_valid), reply.reply_byte == TYPE_ECHO_REPLY, "bad reply type")

endmodule

bind icmp_echo_responder ier_checker u_ier_checker (.*);

[tb/icmp_echo_checker.sv]
`timescale 1ns / 1ps

module icmp_echo_checker import ier_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  ier_req_t    request,
  input  logic        reply_valid,
  input  ier_reply_t  reply,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          outstanding
);

  localparam int AW = $clog2(BUFFER_BYTES);

  logic [7:0]       msg_buf [BUFFER_BYTES];
  logic [6:0]       msg_len;
  logic             msg_over;
  logic [SUM_W-1:0] word_acc;
  logic [31:0]      local_ip;
  int               err_cnt = 0;
  ier_reply_t       expected_replies[$];

  always @(posedge clk) begin : watch
    ier_reply_t want;
    ier_reply_t item;
    logic [16:0] fold;
    logic [15:0] ck;
    if (rst) begin
      msg_len = '0;
      msg_over = 1'b0;
      word_acc = '0;
      local_ip = '0;
      expected_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        local_ip = cfg_data;
      end

      if (reply_valid) begin
        if (expected_replies.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected reply: expected none, actual byte=%02h last=%b addr=%08h",
                   $time, reply.reply_byte, reply.reply_last, reply.reply_addr);
        end else begin
          want = expected_replies.pop_front();
          if (reply.reply_byte !== want.reply_byte) begin
            err_cnt++;
            $display("%0t: reply_byte mismatch: expected %02h, actual %02h",
                     $time, want.reply_byte, reply.reply_byte);
          end
          if (reply.reply_last !== want.reply_last) begin
            err_cnt++;
            $display("%0t: reply_last mismatch: expected %b, actual %b",
                     $time, want.reply_last, reply.reply_last);
          end
          if (reply.reply_addr !== want.reply_addr) begin
            err_cnt++;
            $display("%0t: reply_addr mismatch: expected %08h, actual %08h",
                     $time, want.reply_addr, reply.reply_addr);
          end
        end
      end

      if (start && !busy) begin
        if (msg_len < BUFFER_BYTES) begin
          msg_buf[msg_len[AW-1:0]] = request.data_byte;
          if (msg_len >= SUM_START) begin
            // even index is the high half of its word
            word_acc = word_acc + (msg_len[0] ? SUM_W'(request.data_byte)
                                              : SUM_W'({request.data_byte, 8'h00}));
          end
          msg_len = msg_len + 7'd1;
        end else begin
          msg_over = 1'b1;
        end

        if (request.last_byte) begin
          if (!msg_over && msg_len >= HEADER_BYTES && msg_buf[0] == TYPE_ECHO_REQUEST &&
              request.dest_addr == local_ip) begin
            fold = {1'b0, word_acc[15:0]} + 17'(word_acc[SUM_W-1:16]);
            fold = {1'b0, fold[15:0]} + 17'(fold[16]);
            ck = ~fold[15:0];
            item.reply_last = 1'b0;
            item.reply_addr = request.source_addr;
            item.reply_byte = TYPE_ECHO_REPLY;
            expected_replies.push_back(item);
            item.reply_byte = CODE_ECHO_REPLY;
            expected_replies.push_back(item);
            item.reply_byte = ck[15:8];
            expected_replies.push_back(item);
            item.reply_byte = ck[7:0];
            expected_replies.push_back(item);
            for (int i = SUM_START; i < msg_len; i++) begin
              item.reply_byte = msg_buf[i];
              item.reply_last = (i == msg_len - 1);
              expected_replies.push_back(item);
            end
          end
          msg_len = '0;
          msg_over = 1'b0;
          word_acc = '0;
        end
      end
    end
    outstanding <= expected_replies.size();
    mismatches <= err_cnt;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ier_pkg::*;

  localparam int BUFFER_BYTES = 64;

  typedef enum {MSG_ECHO, MSG_SHORT, MSG_BAD_TYPE, MSG_FOREIGN, MSG_OVERFLOW} msg_kind_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  ier_req_t    request;
  logic        reply_valid;
  ier_reply_t  reply;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;
  int          mismatches;
  int          outstanding;
  logic [31:0] local_ip = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  icmp_echo_responder #(.BUFFER_BYTES(BUFFER_BYTES)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .reply_valid(reply_valid), .reply(reply),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  icmp_echo_checker #(.BUFFER_BYTES(BUFFER_BYTES)) echo_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .request(request),
    .reply_valid(reply_valid), .reply(reply),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // drop start, let every pending reply drain, then let the bus stay quiet for a while
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_local(input logic [31:0] addr);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    local_ip = addr;
  endtask

  // fill < 0 gives random content
  task automatic send_message(input msg_kind_t kind, input int len, input int fill,
                              input logic [31:0] src, input bit idle_on);
    ier_req_t r;
    int gap;
    for (int i = 0; i < len; i++) begin
      r.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
      if (i == 0) begin
        if (kind == MSG_BAD_TYPE) begin
          do r.data_byte = 8'($urandom); while (r.data_byte == TYPE_ECHO_REQUEST);
        end else begin
          r.data_byte = TYPE_ECHO_REQUEST;
        end
      end
      r.last_byte = (i == len - 1);
      r.source_addr = r.last_byte ? src : $urandom;
      if (!r.last_byte) begin
        r.dest_addr = $urandom;
      end else if (kind == MSG_FOREIGN) begin
        r.dest_addr = local_ip ^ ($urandom | 32'h1);
      end else begin
        r.dest_addr = local_ip;
      end
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      start <= 1'b1;
      request <= r;
      @(posedge clk);
      while (busy) @(posedge clk);
    end
  endtask

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    msg_kind_t kind;
    int len;
    int pick;
    int sent;
    int m;
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed
    set_local(32'hFFFF_FFFF);
    send_message(MSG_ECHO, 8, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_message(MSG_ECHO, 9, 8'h00, 32'h0000_0000, 1'b1);
    send_message(MSG_SHORT, 1, -1, $urandom, 1'b0);
    send_message(MSG_BAD_TYPE, 8, -1, $urandom, 1'b1);

    // random
    for (int phase = 0; phase < 3; phase++) begin
      set_local(phase == 0 ? 32'h0 : $urandom);
      sent = 0;
      m = 0;
      while (sent < 20 || (phase == 1 && m < 3)) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) kind = MSG_ECHO;
        else if (pick < 78) kind = MSG_SHORT;
        else if (pick < 86) kind = MSG_BAD_TYPE;
        else if (pick < 93) kind = MSG_FOREIGN;
        else kind = MSG_OVERFLOW;
        if (phase == 1 && m < 3) begin
          kind = (m == 0) ? MSG_OVERFLOW : (m == 1) ? MSG_FOREIGN : MSG_ECHO;
        end
        case (kind)
          MSG_SHORT: len = $urandom_range(1, HEADER_BYTES - 1);
          MSG_OVERFLOW: len = $urandom_range(BUFFER_BYTES + 1, BUFFER_BYTES + 4);
          MSG_ECHO: len = ($urandom_range(0, 9) == 0) ?
                          $urandom_range(21, BUFFER_BYTES) : $urandom_range(HEADER_BYTES, 20);
          default: len = $urandom_range(HEADER_BYTES, 20);
        endcase
        if (phase == 1 && m == 2) len = BUFFER_BYTES;
        send_message(kind, len, -1, $urandom, $urandom_range(0, 2) != 0);
        if ($urandom_range(0, 5) == 0) wait_idle();
        sent += len;
        m++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[icmp_echo_responder.f]
+incdir+src
src/ier_pkg.sv
src/ier_ctrl.sv
src/ier_datapath.sv
src/icmp_echo_responder.sv
src/ier_checker.sv
tb/icmp_echo_checker.sv
tb/testbench.sv
